[hw/rtl/maeu_pkg.sv]
// shared types, opcodes and helper functions for the execute unit
`timescale 1ns / 1ps

package maeu_pkg;

    // opcodes
    localparam logic [3:0] OP_NOP  = 4'd0;
    localparam logic [3:0] OP_MOVR = 4'd1;
    localparam logic [3:0] OP_MOVI = 4'd2;
    localparam logic [3:0] OP_ADDR = 4'd3;
    localparam logic [3:0] OP_ADDI = 4'd4;
    localparam logic [3:0] OP_SUBR = 4'd5;
    localparam logic [3:0] OP_SUBI = 4'd6;
    localparam logic [3:0] OP_PUSH = 4'd7;
    localparam logic [3:0] OP_POP  = 4'd8;
    localparam logic [3:0] OP_STR  = 4'd9;
    localparam logic [3:0] OP_LDR  = 4'd10;

    localparam int unsigned REG_COUNT = 16;
    localparam int unsigned WORD_W    = 32;

    // decoded instruction
    typedef struct packed {
        logic [3:0]         op;
        logic [3:0]         dst_reg;
        logic [3:0]         src1_reg;
        logic [3:0]         src2_reg;
        logic [31:0]        imm;
        logic [15:0]        reg_list;
        logic signed [31:0] offset;
    } t_in_item;

    // result of one instruction
    typedef struct packed {
        logic [31:0] result_value;
        logic [31:0] sp_value;
        logic        mem_error;
    } t_out_item;

    // index of the lowest set bit of a register list
    function automatic logic [3:0] f_low_idx(input logic [15:0] m);
        logic [3:0] idx;
        idx = '0;
        for (int i = 15; i >= 0; i--) begin
            if (m[i]) begin
                idx = 4'(i);
            end
        end
        return idx;
    endfunction

    // number of listed registers
    function automatic logic [4:0] f_count(input logic [15:0] m);
        logic [4:0] n;
        n = '0;
        for (int i = 0; i < 16; i++) begin
            n = n + 5'(m[i]);
        end
        return n;
    endfunction

endpackage

[hw/rtl/maeu_ram.sv]
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module maeu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/mini_arm_execute_unit_top.sv]
// execute unit: register file ram, stack ram and the instruction sequencer
// sequence: mov/add/sub/str read operands, execute and finish, ldr adds a load data state,
//   push lowers the stack pointer once, then stores each listed register in turn, pop loads each in turn,
//   and pop also waits when the stack pointer is listed below another register
// throughput: one instruction at a time, next accept in the cycle after the result is loaded;
//   set by the single read port of the register file ram and the single stack ram port
// reset: synchronous active low; registers and stack pointer read zero, stack ram undefined
`timescale 1ns / 1ps

module mini_arm_execute_unit_top
    import maeu_pkg::*;
#(
    parameter int STACK_WORDS = 1024,
    parameter int SP_INDEX    = 13
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    localparam int         STACK_AW = $clog2(STACK_WORDS);
    localparam logic [3:0] SP_IDX   = 4'(SP_INDEX);

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RDA    = 4'd1;
    localparam logic [3:0] S_RDB    = 4'd2;
    localparam logic [3:0] S_EXEC   = 4'd3;
    localparam logic [3:0] S_LDW    = 4'd4;
    localparam logic [3:0] S_PUSHSP = 4'd5;
    localparam logic [3:0] S_PUSH   = 4'd6;
    localparam logic [3:0] S_POP    = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;

    // byte address falls inside the stack
    function automatic logic f_in_range(input logic [31:0] addr);
        return addr[31:2] < 30'(STACK_WORDS);
    endfunction

    logic [3:0]            r_state, n_state;
    t_in_item              r_item, n_item;
    logic [31:0]           r_a, n_a;
    logic [31:0]           r_res, n_res;
    logic                  r_err, n_err;
    logic [31:0]           r_sp, n_sp;
    logic [REG_COUNT-1:0]  r_rf_vld, n_rf_vld;
    logic [15:0]           r_mask, n_mask;
    logic [31:0]           r_addr, n_addr;
    logic                  r_pend, n_pend;
    logic                  r_pend_ok, n_pend_ok;
    logic [3:0]            r_idx, n_idx;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out, n_out;

    logic                  rf_we;
    logic [3:0]            rf_waddr;
    logic [31:0]           rf_wdata;
    logic [3:0]            rf_raddr;
    logic [31:0]           rf_q;
    logic [31:0]           rd_data;

    logic                  st_we;
    logic [STACK_AW-1:0]   st_waddr;
    logic [31:0]           st_wdata;
    logic [STACK_AW-1:0]   st_raddr;
    logic [31:0]           st_q;

    logic [31:0]           mem_addr;
    logic [31:0]           alu_val;
    logic                  alu_wb;
    logic [3:0]            low_idx;

    // register file and stack memories
    maeu_ram #(.WIDTH(WORD_W), .DEPTH(REG_COUNT)) u_rf (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_raddr (rf_raddr),
        .o_rdata (rf_q)
    );

    maeu_ram #(.WIDTH(WORD_W), .DEPTH(STACK_WORDS)) u_stack (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_q)
    );

    // register read data: stack pointer lives in its own register, unwritten entries read zero
    always_comb begin
        if (r_idx == SP_IDX) begin
            rd_data = r_sp;
        end else if (r_rf_vld[r_idx]) begin
            rd_data = rf_q;
        end else begin
            rd_data = '0;
        end
    end

    assign mem_addr = r_a + 32'(r_item.offset);
    assign low_idx  = f_low_idx(r_mask);

    // alu result for register writing ops
    always_comb begin
        alu_wb  = 1'b1;
        alu_val = '0;
        unique case (r_item.op)
            OP_MOVR: alu_val = r_a;
            OP_MOVI: alu_val = r_item.imm;
            OP_ADDR: alu_val = r_a + rd_data;
            OP_ADDI: alu_val = r_a + r_item.imm;
            OP_SUBR: alu_val = r_a - rd_data;
            OP_SUBI: alu_val = r_a - r_item.imm;
            default: alu_wb  = 1'b0;
        endcase
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_a         = r_a;
        n_res       = r_res;
        n_err       = r_err;
        n_sp        = r_sp;
        n_rf_vld    = r_rf_vld;
        n_mask      = r_mask;
        n_addr      = r_addr;
        n_pend      = r_pend;
        n_pend_ok   = r_pend_ok;
        n_idx       = r_idx;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;

        rf_we    = 1'b0;
        rf_waddr = r_item.dst_reg;
        rf_wdata = alu_val;
        rf_raddr = r_item.src1_reg;
        st_we    = 1'b0;
        st_waddr = r_addr[STACK_AW+1:2];
        st_wdata = rd_data;
        st_raddr = r_sp[STACK_AW+1:2];

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_item = i_data;
                    n_res  = '0;
                    n_err  = 1'b0;
                    n_mask = i_data.reg_list;
                    n_pend = 1'b0;
                    if (i_data.op == OP_PUSH) begin
                        n_state = S_PUSHSP;
                    end else if (i_data.op == OP_POP) begin
                        n_state = S_POP;
                    end else begin
                        n_state = S_RDA;
                    end
                end
            end
            S_RDA: begin
                rf_raddr = r_item.src1_reg;
                n_idx    = r_item.src1_reg;
                n_state  = S_RDB;
            end
            S_RDB: begin
                n_a      = rd_data;
                rf_raddr = (r_item.op == OP_STR) ? r_item.dst_reg : r_item.src2_reg;
                n_idx    = rf_raddr;
                n_state  = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_FIN;
                if (alu_wb) begin
                    n_res = alu_val;
                    if (r_item.dst_reg == SP_IDX) begin
                        n_sp = alu_val;
                    end else begin
                        rf_we                      = 1'b1;
                        n_rf_vld[r_item.dst_reg]   = 1'b1;
                    end
                end else if (r_item.op == OP_STR) begin
                    if (f_in_range(mem_addr)) begin
                        st_we    = 1'b1;
                        st_waddr = mem_addr[STACK_AW+1:2];
                    end else begin
                        n_err = 1'b1;
                    end
                end else if (r_item.op == OP_LDR) begin
                    st_raddr = mem_addr[STACK_AW+1:2];
                    if (f_in_range(mem_addr)) begin
                        n_state = S_LDW;
                    end else begin
                        n_err = 1'b1;
                    end
                end
            end
            S_LDW: begin
                // load data back from the stack
                n_res    = st_q;
                rf_wdata = st_q;
                if (r_item.dst_reg == SP_IDX) begin
                    n_sp = st_q;
                end else begin
                    rf_we                    = 1'b1;
                    n_rf_vld[r_item.dst_reg] = 1'b1;
                end
                n_state = S_FIN;
            end
            S_PUSHSP: begin
                // lower the stack pointer once for the whole list
                n_sp    = r_sp - (32'(f_count(r_mask)) << 2);
                n_addr  = n_sp;
                n_state = S_PUSH;
            end
            S_PUSH: begin
                // store the register read last cycle
                if (r_pend) begin
                    if (f_in_range(r_addr)) begin
                        st_we = 1'b1;
                    end else begin
                        n_err = 1'b1;
                    end
                    n_addr = r_addr + 32'd4;
                end
                // read the next listed register
                if (r_mask != '0) begin
                    rf_raddr = low_idx;
                    n_idx    = low_idx;
                    n_mask   = r_mask & (r_mask - 16'd1);
                    n_pend   = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_mask == '0 && !r_pend) begin
                    n_state = S_FIN;
                end
            end
            S_POP: begin
                // write back the word loaded last cycle
                if (r_pend) begin
                    if (r_pend_ok) begin
                        n_res    = st_q;
                        rf_waddr = r_idx;
                        rf_wdata = st_q;
                        if (r_idx == SP_IDX) begin
                            n_sp = st_q + 32'd4;
                        end else begin
                            rf_we           = 1'b1;
                            n_rf_vld[r_idx] = 1'b1;
                        end
                    end else begin
                        n_err = 1'b1;
                    end
                end
                // next load waits when the stack pointer itself is being loaded
                if (r_mask != '0 && !(r_pend && r_idx == SP_IDX)) begin
                    st_raddr  = r_sp[STACK_AW+1:2];
                    n_pend_ok = f_in_range(r_sp);
                    n_idx     = low_idx;
                    n_mask    = r_mask & (r_mask - 16'd1);
                    n_sp      = r_sp + 32'd4;
                    n_pend    = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_mask == '0 && !r_pend) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // load the output register once it is free
                if (!r_out_valid || i_ready) begin
                    n_out.result_value = r_res;
                    n_out.sp_value     = r_sp;
                    n_out.mem_error    = r_err;
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_rf_vld    <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_rf_vld    <= n_rf_vld;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_a       <= n_a;
        r_res     <= n_res;
        r_err     <= n_err;
        r_mask    <= n_mask;
        r_addr    <= n_addr;
        r_pend_ok <= n_pend_ok;
        r_idx     <= n_idx;
        r_out     <= n_out;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // a transfer in always starts a sequence
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state != S_IDLE))
        else $error("accepted instruction did not start");

    // the stack pointer is never kept in the register file ram
    a_no_sp_ram_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rf_we |-> (rf_waddr != SP_IDX))
        else $error("stack pointer written to register ram");

    // a pending stack pointer load blocks the next load
    a_pop_sp_interlock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP && r_pend && r_idx == SP_IDX) |=> !r_pend)
        else $error("pop issued a load behind a stack pointer load");

    // no access is left in flight when the result is formed
    a_fin_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> !r_pend)
        else $error("result formed with a pending access");

    // the stack ram is never read and written in the same pop or ldr data cycle
    a_no_store_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP || r_state == S_LDW) |-> !st_we)
        else $error("stack write during a load sequence");

endmodule

[verif/mini_arm_execute_unit_top_tb.sv]
// self-checking testbench for the execute unit: directed table, then random instruction streams
`timescale 1ns / 1ps

module mini_arm_execute_unit_top_tb;
    import maeu_pkg::*;

    localparam int STACK_WORDS = 1024;
    localparam int SP_INDEX    = 13;
    localparam logic [3:0] SP_REG = 4'(SP_INDEX);
    localparam logic [3:0] OP_FIRST_UNUSED = OP_LDR + 4'd1;
    localparam logic [3:0] OP_LAST_UNUSED  = 4'd15;

    localparam int RANDOM_PER_PHASE = 330;
    localparam int DRAW_TRIES       = 8;
    localparam int SETTLE_CYCLES    = 40;
    localparam int DRAIN_LIMIT      = 5000;
    localparam int SEND_IDLE_PCT [3] = '{9, 60, 0};
    localparam int RECV_IDLE_PCT [3] = '{60, 9, 0};

    localparam bit KNOWN = 1'b1;
    localparam bit PRED  = 1'b0;

    // one row of the directed table
    typedef struct packed {
        t_in_item  instr;
        bit        has_result;
        t_out_item result;
    } t_directed_row;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    t_in_item  i_data  = '0;
    logic      i_ready = 1'b0;
    logic      o_ready;
    logic      o_valid;
    t_out_item o_data;

    // architectural state mirrored by the predictor
    logic [31:0] arch_regs [REG_COUNT];
    logic [31:0] stack_words [STACK_WORDS];
    bit          stack_written [STACK_WORDS];
    int          written_words [$];

    t_out_item     expected_results [$];
    t_directed_row directed_rows [$];
    int            fail_count    = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;

    mini_arm_execute_unit_top #(
        .STACK_WORDS(STACK_WORDS),
        .SP_INDEX   (SP_INDEX)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // run limit
    initial begin
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // store a word, returns 1 when the address is outside the stack
    function automatic bit stack_write(input logic [31:0] addr, input logic [31:0] data);
        logic [31:0] w;
        w = addr >> 2;
        if (w >= STACK_WORDS) begin
            return 1'b1;
        end
        if (!stack_written[w]) begin
            stack_written[w] = 1'b1;
            written_words.push_back(int'(w));
        end
        stack_words[w] = data;
        return 1'b0;
    endfunction

    // load a word, returns 1 when the address is outside the stack
    function automatic bit stack_read(input logic [31:0] addr, output logic [31:0] data,
                                      inout bit unwritten);
        logic [31:0] w;
        w = addr >> 2;
        data = '0;
        if (w >= STACK_WORDS) begin
            return 1'b1;
        end
        if (!stack_written[w]) begin
            unwritten = 1'b1;
        end
        data = stack_words[w];
        return 1'b0;
    endfunction

    // execute one instruction on the mirrored state and build its result
    function automatic void execute_instr(input t_in_item it, output t_out_item res,
                                          output bit unwritten);
        logic [31:0] value;
        logic [31:0] loaded;
        int          n;
        int          j;
        value = '0;
        res = '0;
        unwritten = 1'b0;
        case (it.op)
            OP_MOVR: value = arch_regs[it.src1_reg];
            OP_MOVI: value = it.imm;
            OP_ADDR: value = arch_regs[it.src1_reg] + arch_regs[it.src2_reg];
            OP_ADDI: value = arch_regs[it.src1_reg] + it.imm;
            OP_SUBR: value = arch_regs[it.src1_reg] - arch_regs[it.src2_reg];
            OP_SUBI: value = arch_regs[it.src1_reg] - it.imm;
            OP_PUSH: begin
                // lower sp first, so a listed sp stores the lowered value
                n = 0;
                for (int i = 0; i < REG_COUNT; i++) begin
                    n += int'(it.reg_list[i]);
                end
                arch_regs[SP_REG] = arch_regs[SP_REG] - 32'(4 * n);
                j = 0;
                for (int i = 0; i < REG_COUNT; i++) begin
                    if (it.reg_list[i]) begin
                        if (stack_write(arch_regs[SP_REG] + 32'(4 * j), arch_regs[i])) begin
                            res.mem_error = 1'b1;
                        end
                        j++;
                    end
                end
            end
            OP_POP: begin
                // sp advances after every load, also after a failed one
                for (int i = 0; i < REG_COUNT; i++) begin
                    if (it.reg_list[i]) begin
                        if (stack_read(arch_regs[SP_REG], loaded, unwritten)) begin
                            res.mem_error = 1'b1;
                        end else begin
                            arch_regs[i] = loaded;
                            value = loaded;
                        end
                        arch_regs[SP_REG] = arch_regs[SP_REG] + 32'd4;
                    end
                end
            end
            OP_STR: begin
                if (stack_write(arch_regs[it.src1_reg] + it.offset, arch_regs[it.dst_reg])) begin
                    res.mem_error = 1'b1;
                end
            end
            OP_LDR: begin
                if (stack_read(arch_regs[it.src1_reg] + it.offset, loaded, unwritten)) begin
                    res.mem_error = 1'b1;
                end else begin
                    arch_regs[it.dst_reg] = loaded;
                    value = loaded;
                end
            end
            default: ;
        endcase
        if (it.op inside {OP_MOVR, OP_MOVI, OP_ADDR, OP_ADDI, OP_SUBR, OP_SUBI}) begin
            arch_regs[it.dst_reg] = value;
        end
        res.result_value = value;
        res.sp_value = arch_regs[SP_REG];
    endfunction

    // directed table row
    function automatic t_directed_row drow(input logic [3:0] op, input logic [3:0] d,
                                           input logic [3:0] s1, input logic [3:0] s2,
                                           input logic [31:0] imm, input logic [15:0] list,
                                           input logic [31:0] off, input bit has,
                                           input logic [31:0] rv, input logic [31:0] sp,
                                           input logic err);
        t_directed_row row;
        row.instr = '{op, d, s1, s2, imm, list, off};
        row.has_result = has;
        row.result = '{rv, sp, err};
        return row;
    endfunction

    // send one instruction, with random idle cycles ahead of it
    task automatic send_instr(input t_in_item it, input t_out_item exp);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= it;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        expected_results.push_back(exp);
        @(negedge i_clk);
    endtask

    // hold off the sender until every result has come back
    task automatic wait_all_results();
        i_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (expected_results.size() != 0);
    endtask

    // receiver stalls
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // result check against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_out_item exp;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected transfer: result_value %h sp_value %h mem_error %b",
                       o_data.result_value, o_data.sp_value, o_data.mem_error);
                fail_count++;
            end else begin
                exp = expected_results.pop_front();
                if (o_data.result_value !== exp.result_value) begin
                    $error("result_value: expected %h, got %h",
                           exp.result_value, o_data.result_value);
                    fail_count++;
                end
                if (o_data.sp_value !== exp.sp_value) begin
                    $error("sp_value: expected %h, got %h", exp.sp_value, o_data.sp_value);
                    fail_count++;
                end
                if (o_data.mem_error !== exp.mem_error) begin
                    $error("mem_error: expected %b, got %b", exp.mem_error, o_data.mem_error);
                    fail_count++;
                end
            end
        end
    end

    // stimulus
    initial begin : stimulus
        t_in_item    it;
        t_out_item   predicted;
        bit          unwritten;
        logic [31:0] saved_regs [REG_COUNT];
        logic [31:0] addr;
        int          sel;
        int          drain_cycles;

        foreach (arch_regs[r]) begin
            arch_regs[r] = '0;
        end
        send_idle_pct = SEND_IDLE_PCT[0];
        recv_idle_pct = RECV_IDLE_PCT[0];

        // directed table: arithmetic wrap, stack bounds, sp in lists, unused opcodes
        directed_rows.push_back(drow(OP_NOP, 0, 0, 0, 0, 0, 0, KNOWN, 0, 0, 0));
        directed_rows.push_back(drow(OP_MOVI, 0, 0, 0, '1, 0, 0, KNOWN, '1, 0, 0));
        directed_rows.push_back(drow(OP_ADDI, 1, 0, 0, 1, 0, 0, KNOWN, 0, 0, 0));
        directed_rows.push_back(drow(OP_SUBI, 2, 1, 0, 1, 0, 0, KNOWN, '1, 0, 0));
        directed_rows.push_back(drow(OP_MOVR, 3, 0, 0, 0, 0, 0, KNOWN, '1, 0, 0));
        directed_rows.push_back(drow(OP_ADDR, 4, 0, 3, 0, 0, 0, PRED, 0, 0, 0));
        directed_rows.push_back(drow(OP_SUBR, 5, 1, 0, 0, 0, 0, PRED, 0, 0, 0));
        // push below address zero wraps out of the stack
        directed_rows.push_back(drow(OP_PUSH, 0, 0, 0, 0, 16'h0001, 0, KNOWN, 0,
                                     32'hFFFF_FFFC, 1));
        directed_rows.push_back(drow(OP_LDR, 6, 1, 0, 0, 0, 32'h7FFF_FFFF, KNOWN, 0,
                                     32'hFFFF_FFFC, 1));
        directed_rows.push_back(drow(OP_STR, 0, 1, 0, 0, 0, 32'h8000_0000, KNOWN, 0,
                                     32'hFFFF_FFFC, 1));
        directed_rows.push_back(drow(OP_MOVI, SP_REG, 0, 0, 32'h800, 0, 0, KNOWN,
                                     32'h800, 32'h800, 0));
        directed_rows.push_back(drow(OP_MOVI, 15, 0, 0, 32'hA5A5_A5A5, 0, 0, PRED, 0, 0, 0));
        // full and empty lists, sp included in the full ones
        directed_rows.push_back(drow(OP_PUSH, 0, 0, 0, 0, 16'hFFFF, 0, PRED, 0, 0, 0));
        directed_rows.push_back(drow(OP_POP, 0, 0, 0, 0, 16'hFFFF, 0, PRED, 0, 0, 0));
        directed_rows.push_back(drow(OP_PUSH, 0, 0, 0, 0, 16'h0000, 0, PRED, 0, 0, 0));
        directed_rows.push_back(drow(OP_POP, 0, 0, 0, 0, 16'h0000, 0, PRED, 0, 0, 0));
        // negative and unaligned offsets
        directed_rows.push_back(drow(OP_STR, 15, SP_REG, 0, 0, 0, -32'sd4, PRED, 0, 0, 0));
        directed_rows.push_back(drow(OP_LDR, 7, SP_REG, 0, 0, 0, -32'sd3, PRED, 0, 0, 0));
        // last stack word and the first one past it
        directed_rows.push_back(drow(OP_MOVI, 8, 0, 0, 0, 0, 0, PRED, 0, 0, 0));
        directed_rows.push_back(drow(OP_STR, 15, 8, 0, 0, 0, 32'hFFC, PRED, 0, 0, 0));
        directed_rows.push_back(drow(OP_STR, 15, 8, 0, 0, 0, 32'h1000, PRED, 0, 0, 0));
        directed_rows.push_back(drow(OP_MOVI, SP_REG, 0, 0, 32'hFFC, 0, 0, KNOWN,
                                     32'hFFC, 32'hFFC, 0));
        directed_rows.push_back(drow(OP_POP, 0, 0, 0, 0, 16'h0003, 0, PRED, 0, 0, 0));
        directed_rows.push_back(drow(OP_FIRST_UNUSED, 9, 9, 9, '1, '1, '1, PRED, 0, 0, 0));
        directed_rows.push_back(drow(OP_LAST_UNUSED, 9, 9, 9, '1, '1, '1, PRED, 0, 0, 0));

        // reset
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            execute_instr(directed_rows[r].instr, predicted, unwritten);
            send_instr(directed_rows[r].instr,
                       directed_rows[r].has_result ? directed_rows[r].result : predicted);
        end

        // random instruction streams, one per idling pattern
        for (int ph = 0; ph < 3; ph++) begin
            if (ph != 0) begin
                wait_all_results();
            end
            send_idle_pct = SEND_IDLE_PCT[ph];
            recv_idle_pct = RECV_IDLE_PCT[ph];
            for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
                if (k == RANDOM_PER_PHASE / 2) begin
                    wait_all_results();
                end
                // redraw any load that would touch a stack word never written
                for (int tries = 0; tries < DRAW_TRIES; tries++) begin
                    it = {$urandom, $urandom, $urandom};
                    sel = $urandom_range(0, 99);
                    if (sel < 8) begin
                        // move sp into, next to or far from the stack
                        it.op = OP_MOVI;
                        it.dst_reg = SP_REG;
                        case ($urandom_range(0, 7))
                            0: ;
                            1: it.imm = 32'($urandom_range(0, 64));
                            2: it.imm = 32'(STACK_WORDS * 4 - $urandom_range(0, 64));
                            default: it.imm = 32'($urandom_range(16, STACK_WORDS - 16)) << 2;
                        endcase
                    end else if (sel < 40) begin
                        it.op = (sel < 25) ? OP_PUSH : OP_POP;
                        case ($urandom_range(0, 15))
                            0: it.reg_list = '1;
                            1: it.reg_list = '0;
                            2, 3: ;
                            default: it.reg_list = it.reg_list & 16'($urandom);
                        endcase
                    end else if (sel < 50) begin
                        it.op = OP_STR;
                        if ($urandom_range(0, 3) != 0) begin
                            addr = (32'($urandom_range(0, STACK_WORDS - 1)) << 2)
                                 | 32'($urandom_range(0, 3));
                            it.offset = addr - arch_regs[it.src1_reg];
                        end
                    end else if (sel < 62) begin
                        it.op = OP_LDR;
                        if (written_words.size() != 0 && $urandom_range(0, 4) != 0) begin
                            addr = (32'(written_words[$urandom_range(0,
                                        written_words.size() - 1)]) << 2)
                                 | 32'($urandom_range(0, 3));
                            it.offset = addr - arch_regs[it.src1_reg];
                        end
                    end else if (sel < 66) begin
                        it.op = ($urandom_range(0, 1) == 0) ? OP_NOP
                              : 4'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
                    end else begin
                        // mov, add, sub, mostly sparing sp
                        it.op = 4'($urandom_range(OP_MOVR, OP_SUBI));
                        if (it.dst_reg == SP_REG && $urandom_range(0, 3) != 0) begin
                            it.dst_reg = 4'd0;
                        end
                        case ($urandom_range(0, 7))
                            0: it.imm = '0;
                            1: it.imm = '1;
                            2: it.imm = 32'h8000_0000;
                            default: ;
                        endcase
                    end
                    saved_regs = arch_regs;
                    execute_instr(it, predicted, unwritten);
                    if (!unwritten) begin
                        break;
                    end
                    arch_regs = saved_regs;
                end
                if (unwritten) begin
                    it.op = OP_NOP;
                    execute_instr(it, predicted, unwritten);
                end
                send_instr(it, predicted);
            end
        end

        // drain, then let the pipeline settle
        i_valid <= 1'b0;
        drain_cycles = 0;
        while (expected_results.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(negedge i_clk);
            drain_cycles++;
        end
        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            fail_count++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
